// ----- design/lss_pkg.sv -----
package lss_pkg;

   localparam int MAX_PAIRS       = 1024;
   localparam int SAMPLE_BITS     = 20;
   localparam int SLOPE_FRAC_BITS = 16;

   localparam int SKIP_W  = 10;
   localparam int SLOPE_W = 48;

   localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
   localparam int SX_W   = SAMPLE_BITS + $clog2(MAX_PAIRS);
   localparam int SXX_W  = 2 * SAMPLE_BITS + $clog2(MAX_PAIRS);

   // product unit consumes one digit of the short operand per cycle, msb first
   localparam int DIG_BITS = 16;
   localparam int NDIG     = (SX_W + DIG_BITS - 1) / DIG_BITS;
   localparam int DIG_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int BEXT_W   = NDIG * DIG_BITS;
   localparam int ACC_W    = SXX_W + BEXT_W;

   // divider
   localparam int DVD_W    = ACC_W + SLOPE_FRAC_BITS;
   localparam int DIVCNT_W = $clog2(DVD_W);

   localparam logic [SLOPE_W-1:0] POS_LIM = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] NEG_MAG = {1'b1, {(SLOPE_W-1){1'b0}}};

   // product codes
   localparam logic [1:0] OP_NSXY = 2'd0;
   localparam logic [1:0] OP_SXSY = 2'd1;
   localparam logic [1:0] OP_NSXX = 2'd2;
   localparam logic [1:0] OP_SXSX = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_sample;
      logic signed [SAMPLE_BITS-1:0] y_sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope_value;
      logic                      degenerate;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       step;
      logic       first;
      logic       store;
      logic       div_load;
      logic       div_step;
      logic       out_load;
      logic [1:0] op;
   } ctl_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/lss_ctrl.sv -----
module lss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_stall,
   input  lss_pkg::dp_status_type status,
   output lss_pkg::ctl_cmd_type   cmd
);
   import lss_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_STORE  = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_RESULT = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [DIG_W-1:0]    dig_ff, dig_in;
   logic [DIVCNT_W-1:0] div_cnt_ff, div_cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      dig_in     = dig_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.op     = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               op_in    = OP_NSXY;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            dig_in   = DIG_W'(NDIG - 1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.step  = 1'b1;
            cmd.first = (dig_ff == DIG_W'(NDIG - 1));
            if (dig_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               dig_in = dig_ff - 1'b1;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (op_ff == OP_SXSX) begin
               state_in = ST_CHECK;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_CHECK: begin
            if (status.den_zero) begin
               state_in = ST_RESULT;
            end else begin
               cmd.div_load = 1'b1;
               div_cnt_in   = DIVCNT_W'(DVD_W - 1);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         op_ff      <= OP_NSXY;
         dig_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         dig_ff     <= dig_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// ----- design/lss_dpath.sv -----
module lss_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  lss_pkg::req_type            req_data,
   input  logic                        csr_wr_en,
   input  logic [lss_pkg::SKIP_W-1:0]  csr_wr_data,
   input  lss_pkg::ctl_cmd_type        cmd,
   output lss_pkg::dp_status_type      status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lss_pkg::rsp_type            rsp_data
);
   import lss_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);

   logic [SKIP_W-1:0]       skip_count_ff;
   logic [SKIP_W-1:0]       skipped_ff, skipped_in;
   logic [CNT_W-1:0]        pair_ff, pair_in;
   logic signed [SX_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [SXX_W-1:0] sum_xx_ff, sum_xx_in, sum_xy_ff, sum_xy_in;

   logic signed [SAMPLE_BITS-1:0]   x_s, y_s;
   logic signed [2*SAMPLE_BITS-1:0] xx_prod, xy_prod;

   logic signed [SXX_W-1:0]          mul_a;
   logic signed [BEXT_W-1:0]         mul_b;
   logic signed [DIG_BITS:0]         digit;
   logic signed [SXX_W+DIG_BITS:0]   prod;
   logic [BEXT_W-1:0]                bsh_ff;
   logic signed [ACC_W-1:0]          acc_ff, acc_in;
   logic signed [ACC_W-1:0]          hold_ff, num_ff, den_ff;

   logic              neg_ff;
   logic [DVD_W-1:0]  dq_ff;
   logic [ACC_W-1:0]  rem_ff, den_mag_ff;
   logic [ACC_W-1:0]  num_mag, den_mag;
   logic [ACC_W:0]    rem_sh, trial;
   logic              qbit;

   logic [SLOPE_W-1:0] slope_mag, slope_out;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign x_s     = req_data.x_sample;
   assign y_s     = req_data.y_sample;
   assign xx_prod = x_s * x_s;
   assign xy_prod = x_s * y_s;

   // window accumulation
   always_comb begin
      skipped_in = skipped_ff;
      pair_in    = pair_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      sum_xx_in  = sum_xx_ff;
      sum_xy_in  = sum_xy_ff;
      if (cmd.out_load) begin
         skipped_in = '0;
         pair_in    = '0;
         sum_x_in   = '0;
         sum_y_in   = '0;
         sum_xx_in  = '0;
         sum_xy_in  = '0;
      end else if (cmd.accept) begin
         if (skipped_ff < skip_count_ff) begin
            skipped_in = skipped_ff + 1'b1;
         end else if (pair_ff < MAX_CNT) begin
            pair_in   = pair_ff + 1'b1;
            sum_x_in  = sum_x_ff + SX_W'(x_s);
            sum_y_in  = sum_y_ff + SX_W'(y_s);
            sum_xx_in = sum_xx_ff + SXX_W'(xx_prod);
            sum_xy_in = sum_xy_ff + SXX_W'(xy_prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff <= '0;
         skipped_ff    <= '0;
         pair_ff       <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_xx_ff     <= '0;
         sum_xy_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            skip_count_ff <= csr_wr_data;
         end
         skipped_ff <= skipped_in;
         pair_ff    <= pair_in;
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
         sum_xx_ff  <= sum_xx_in;
         sum_xy_ff  <= sum_xy_in;
      end
   end

   // digit-serial product unit
   always_comb begin
      unique case (cmd.op)
         OP_NSXY: begin
            mul_a = sum_xy_ff;
            mul_b = BEXT_W'($signed({1'b0, pair_ff}));
         end
         OP_SXSY: begin
            mul_a = SXX_W'(sum_y_ff);
            mul_b = BEXT_W'(sum_x_ff);
         end
         OP_NSXX: begin
            mul_a = sum_xx_ff;
            mul_b = BEXT_W'($signed({1'b0, pair_ff}));
         end
         OP_SXSX: begin
            mul_a = SXX_W'(sum_x_ff);
            mul_b = BEXT_W'(sum_x_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign digit  = {cmd.first & bsh_ff[BEXT_W-1], bsh_ff[BEXT_W-1 -: DIG_BITS]};
   assign prod   = mul_a * digit;
   assign acc_in = (cmd.first ? ACC_W'(0) : (acc_ff <<< DIG_BITS)) + ACC_W'(prod);

   // divider operands
   assign num_mag = num_ff[ACC_W-1] ? ACC_W'(-num_ff) : ACC_W'(num_ff);
   assign den_mag = den_ff[ACC_W-1] ? ACC_W'(-den_ff) : ACC_W'(den_ff);
   assign rem_sh  = {rem_ff, dq_ff[DVD_W-1]};
   assign trial   = rem_sh - {1'b0, den_mag_ff};
   assign qbit    = (rem_sh >= {1'b0, den_mag_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bsh_ff <= mul_b;
      end else if (cmd.step) begin
         bsh_ff <= bsh_ff << DIG_BITS;
      end
      if (cmd.step) begin
         acc_ff <= acc_in;
      end
      if (cmd.store) begin
         unique case (cmd.op)
            OP_NSXY: hold_ff <= acc_ff;
            OP_SXSY: num_ff  <= hold_ff - acc_ff;
            OP_NSXX: hold_ff <= acc_ff;
            OP_SXSX: den_ff  <= hold_ff - acc_ff;
            default: hold_ff <= acc_ff;
         endcase
      end
      if (cmd.div_load) begin
         neg_ff     <= num_ff[ACC_W-1] ^ den_ff[ACC_W-1];
         dq_ff      <= DVD_W'(num_mag) << SLOPE_FRAC_BITS;
         rem_ff     <= '0;
         den_mag_ff <= den_mag;
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? trial[ACC_W-1:0] : rem_sh[ACC_W-1:0];
         dq_ff  <= {dq_ff[DVD_W-2:0], qbit};
      end
   end

   // saturation and sign
   always_comb begin
      if (!neg_ff) begin
         slope_mag = (dq_ff > DVD_W'(POS_LIM)) ? POS_LIM : dq_ff[SLOPE_W-1:0];
      end else begin
         slope_mag = (dq_ff > DVD_W'(NEG_MAG)) ? NEG_MAG : dq_ff[SLOPE_W-1:0];
      end
      slope_out = neg_ff ? (~slope_mag + 1'b1) : slope_mag;
   end

   assign status.den_zero = (den_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.slope_value <= status.den_zero ? '0 : $signed(slope_out);
         rsp_data_ff.degenerate  <= status.den_zero;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/least_squares_slope.sv -----
// channel      | ports                               | transaction
// -------------+-------------------------------------+------------------------------
// request      | req_valid, req_stall, req_data      | one (x, y, last) sample pair
// response     | rsp_valid, rsp_stall, rsp_data      | slope and degenerate flag
// csr          | csr_wr_en, csr_wr_data              | skip_count write
//
// while req_stall is low a pair without the last mark is taken every cycle and the sums
// update in that cycle, unless it is skipped or MAX_PAIRS are summed; a last pair holds
// req_stall high through the digit-serial product unit and the divider, skipped if den is 0
// the response register frees the datapath; a stalled response only delays the next last
// reset is synchronous and clears sums, counters, skip_count and rsp_valid
module least_squares_slope (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lss_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lss_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [lss_pkg::SKIP_W-1:0] csr_wr_data
);
   import lss_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_sample),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lss_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- dv/tb_least_squares_slope.sv -----
`timescale 1ns / 100ps

module tb_least_squares_slope;
   import lss_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 160;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};

   typedef enum int {SHAPE_SCATTER, SHAPE_FLAT_X, SHAPE_LINE} window_shape_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [SKIP_W-1:0] csr_wr_data = '0;

   least_squares_slope dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   req_type     pair_queue[$];
   rsp_type     slope_expect[$];
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   logic        req_fire       = 1'b0;
   int unsigned err_count      = 0;
   int unsigned pairs_sent     = 0;
   int unsigned slopes_checked = 0;
   int unsigned flat_slopes    = 0;
   int unsigned skip_writes    = 0;
   int unsigned cycle_count    = 0;

   // shadow of the accumulator state
   logic [SKIP_W-1:0] skip_shadow   = '0;
   longint            sum_x         = 0;
   longint            sum_y         = 0;
   longint            sum_xx        = 0;
   longint            sum_xy        = 0;
   int unsigned       pairs_taken   = 0;
   int unsigned       pairs_skipped = 0;

   always #5 clock = ~clock;

   function automatic rsp_type fit_slope(longint n, longint sx, longint sy, longint sxx,
                                         longint sxy);
      logic signed [127:0] wn, wsx, wsy, wsxx, wsxy, num, den;
      logic [127:0]        num_mag, den_mag, quo;
      logic [SLOPE_W-1:0]  mag;
      rsp_type             r;
      wn   = n;
      wsx  = sx;
      wsy  = sy;
      wsxx = sxx;
      wsxy = sxy;
      num  = wn * wsxy - wsx * wsy;
      den  = wn * wsxx - wsx * wsx;
      r    = '0;
      if (den == 0) begin
         r.degenerate = 1'b1;
      end else begin
         num_mag = num[127] ? -num : num;
         den_mag = den[127] ? -den : den;
         quo     = (num_mag << SLOPE_FRAC_BITS) / den_mag;
         if (num[127] == den[127]) begin
            r.slope_value = (quo > POS_LIM) ? POS_LIM : quo[SLOPE_W-1:0];
         end else begin
            mag           = (quo > NEG_MAG) ? NEG_MAG : quo[SLOPE_W-1:0];
            r.slope_value = -mag;
         end
      end
      return r;
   endfunction

   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (!req_valid || req_fire) begin
            if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pair_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type got, want;
      longint  xv, yv;
      if (reset) begin
         req_fire      <= 1'b0;
         skip_shadow   = '0;
         sum_x         = 0;
         sum_y         = 0;
         sum_xx        = 0;
         sum_xy        = 0;
         pairs_taken   = 0;
         pairs_skipped = 0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (csr_wr_en)
            skip_shadow = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (slope_expect.size() == 0) begin
               err_count++;
               $display("%0t: unexpected transaction, expected none, got slope %0d degenerate %b",
                        $time, got.slope_value, got.degenerate);
            end else begin
               want = slope_expect.pop_front();
               slopes_checked++;
               if (got.slope_value !== want.slope_value) begin
                  err_count++;
                  $display("%0t: slope_value mismatch, expected %0d got %0d",
                           $time, want.slope_value, got.slope_value);
               end
               if (got.degenerate !== want.degenerate) begin
                  err_count++;
                  $display("%0t: degenerate mismatch, expected %b got %b",
                           $time, want.degenerate, got.degenerate);
               end
            end
         end
         if (req_valid && !req_stall) begin
            xv = req_data.x_sample;
            yv = req_data.y_sample;
            pairs_sent++;
            if (pairs_skipped < skip_shadow) begin
               pairs_skipped++;
            end else if (pairs_taken < MAX_PAIRS) begin
               sum_x  += xv;
               sum_y  += yv;
               sum_xx += xv * xv;
               sum_xy += xv * yv;
               pairs_taken++;
            end
            if (req_data.last_sample) begin
               want = fit_slope(longint'(pairs_taken), sum_x, sum_y, sum_xx, sum_xy);
               if (want.degenerate)
                  flat_slopes++;
               slope_expect.push_back(want);
               sum_x         = 0;
               sum_y         = 0;
               sum_xx        = 0;
               sum_xy        = 0;
               pairs_taken   = 0;
               pairs_skipped = 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d slopes outstanding",
                  cycle_count, slope_expect.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_pair(input logic signed [SAMPLE_BITS-1:0] x,
                            input logic signed [SAMPLE_BITS-1:0] y, input bit last);
      req_type p;
      p.x_sample    = x;
      p.y_sample    = y;
      p.last_sample = last;
      pair_queue.push_back(p);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int v;
      case ($urandom_range(7))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2, 3: begin
            v = $urandom_range(128);
            return SAMPLE_BITS'(v - 64);
         end
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   task automatic push_window(input int len, input window_shape_type shape);
      logic signed [SAMPLE_BITS-1:0] fixed_x;
      int base, step, k, x, noise;
      fixed_x = pick_sample();
      base    = $urandom_range(2000);
      base   -= 1000;
      step    = $urandom_range(50, 1);
      k       = $urandom_range(200);
      k      -= 100;
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_FLAT_X: push_pair(fixed_x, pick_sample(), i == len - 1);
            SHAPE_LINE: begin
               x     = base + i * step;
               noise = $urandom_range(32);
               push_pair(SAMPLE_BITS'(x), SAMPLE_BITS'(k * x + noise - 16), i == len - 1);
            end
            default: push_pair(pick_sample(), pick_sample(), i == len - 1);
         endcase
      end
   endtask

   task automatic push_random(input int items);
      int               added;
      int               len;
      int unsigned      pick;
      window_shape_type shape;
      added = 0;
      while (added < items) begin
         pick = $urandom_range(99);
         if (pick < 8)
            len = 1;
         else if (pick < 80)
            len = $urandom_range(12, 2);
         else if (pick < 95)
            len = $urandom_range(40, 13);
         else
            len = $urandom_range(120, 41);
         pick = $urandom_range(99);
         if (pick < 60)
            shape = SHAPE_SCATTER;
         else if (pick < 75)
            shape = SHAPE_FLAT_X;
         else
            shape = (len <= 40) ? SHAPE_LINE : SHAPE_SCATTER;
         push_window(len, shape);
         added += len;
      end
   endtask

   task automatic settle();
      while (pair_queue.size() != 0 || req_valid || slope_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_skip(input logic [SKIP_W-1:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      skip_writes++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 73;
      write_skip('0);
      push_pair(0, 0, 1);
      push_pair(SAMPLE_MIN, SAMPLE_MAX, 0);
      push_pair(SAMPLE_MAX, SAMPLE_MIN, 1);
      push_pair(SAMPLE_MAX, SAMPLE_MAX, 0);
      push_pair(SAMPLE_MIN, SAMPLE_MIN, 1);
      push_pair(5, 1, 0);
      push_pair(5, 9, 0);
      push_pair(5, -3, 1);
      push_pair(0, SAMPLE_MIN, 0);
      push_pair(1, SAMPLE_MAX, 1);
      push_pair(0, 0, 0);
      push_pair(1, 1, 0);
      push_pair(3, 1, 1);
      push_pair(0, 0, 0);
      push_pair(1, -1, 0);
      push_pair(3, -1, 1);

      // last pair still inside the skipped lead-in
      write_skip(3);
      push_pair(1, 1, 0);
      push_pair(2, 2, 1);
      push_pair(1, 1, 0);
      push_pair(2, 2, 0);
      push_pair(3, 3, 0);
      push_pair(4, 4, 0);
      push_pair(6, 5, 1);
      push_random(180);

      send_idle_pct = 73;
      recv_idle_pct = 26;
      write_skip(SKIP_MAX);
      push_window(5, SHAPE_SCATTER);
      write_skip(SKIP_W'(40));
      push_window(3, SHAPE_SCATTER);
      push_window(46, SHAPE_SCATTER);

      write_skip('0);
      push_random(130);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_skip(SKIP_W'($urandom_range(6, 1)));
      push_random(130);
      write_skip(SKIP_W'($urandom_range(2)));
      push_random(130);
      settle();

      $display("sent %0d sample pairs across %0d skip_count settings", pairs_sent, skip_writes);
      $display("checked %0d slope transactions, %0d of them degenerate",
               slopes_checked, flat_slopes);
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lss_pkg.sv
design/lss_ctrl.sv
design/lss_dpath.sv
design/least_squares_slope.sv
dv/tb_least_squares_slope.sv
